// ===== rtl/dcc_edge_interval_packet_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// DCC decoder assertion macros
// Shared assertion wrappers, clocked on clk; DCCPD_ASSERT is qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef DCC_EDGE_INTERVAL_PACKET_DECODER_CORE_MACROS_SVH
`define DCC_EDGE_INTERVAL_PACKET_DECODER_CORE_MACROS_SVH

// Property checked only outside of reset.
`define DCCPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define DCCPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// DCC decoder package
// Widths, codes, register defaults and shared structs of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dccpd_pkg;

  localparam int TimeBits    = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam int PktBits     = 32;
  localparam int CntBits     = 6;

  typedef enum logic [2:0] {
    EV_GLITCH     = 3'd0,
    EV_ONE        = 3'd1,
    EV_WRONG_EDGE = 3'd2,
    EV_ZERO       = 3'd3,
    EV_LONG_GAP   = 3'd4
  } dcc_event_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ONE_MIN      = 3'd0,
    REG_ONE_MAX      = 3'd1,
    REG_ZERO_MIN     = 3'd2,
    REG_ZERO_MAX     = 3'd3,
    REG_PREAMBLE_MIN = 3'd4,
    REG_OWN_ADDRESS  = 3'd5
  } cfg_reg_t;

  localparam logic [TimeBits-1:0] OneMinRst      = 16'd104;
  localparam logic [TimeBits-1:0] OneMaxRst      = 16'd132;
  localparam logic [TimeBits-1:0] ZeroMinRst     = 16'd180;
  localparam logic [TimeBits-1:0] ZeroMaxRst     = 16'd400;
  localparam logic [7:0]          PreambleMinRst = 8'd14;
  localparam logic [7:0]          OwnAddressRst  = 8'd5;

  typedef struct packed {
    logic [TimeBits-1:0] one_min;
    logic [TimeBits-1:0] one_max;
    logic [TimeBits-1:0] zero_min;
    logic [TimeBits-1:0] zero_max;
    logic [7:0]          preamble_min;
    logic [7:0]          own_address;
  } cfg_t;

  typedef struct packed {
    dcc_event_t  event_res;
    logic        packet_done;
    logic        checksum_ok;
    logic        for_this_device;
    logic [7:0]  address;
    logic [7:0]  data;
    logic [7:0]  checksum;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dccpd_ifs.sv =====
// ----------------------------------------------------------------------------
// DCC decoder channel interfaces
// Valid/ready channels for edge words, result words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dccpd_in_if import dccpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TimeBits-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface dccpd_out_if import dccpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       packet_done;
  logic       checksum_ok;
  logic       for_this_device;
  logic [7:0] address;
  logic [7:0] data;
  logic [7:0] checksum;

  modport source (output valid, output event_res, output packet_done, output checksum_ok,
                  output for_this_device, output address, output data, output checksum,
                  input ready);
  modport sink   (input valid, input event_res, input packet_done, input checksum_ok,
                  input for_this_device, input address, input data, input checksum,
                  output ready);
endinterface

interface dccpd_cfg_if import dccpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dcc_edge_interval_packet_decoder_core.sv =====
// ----------------------------------------------------------------------------
// DCC edge-interval packet decoder
// Takes one timer word per track edge and returns one result word per edge.
// Each edge word lands in an input register, is classified and framed
// combinationally, and its result sits in an output register until taken. One
// edge word can be accepted every clock cycle while results are taken; a result
// word passes through the input register and then the output register before it
// is valid, and a stalled result holds back at most one further word.
// Register writes take effect in the cycle after the write and should be made
// while no edge word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcc_edge_interval_packet_decoder_core import dccpd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dccpd_in_if.sink    in_ch,
  dccpd_out_if.source out_ch,
  dccpd_cfg_if.sink   cfg_ch
);

  logic                in_vld_r;
  logic [TimeBits-1:0] in_time_r;
  logic                step;
  logic                res_valid;
  result_t             res;
  cfg_t                cfg;
  dcc_event_t          ev;

  assign step         = in_vld_r && (!res_valid || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_time_r <= in_ch.edge_time;
    end
  end

  dccpd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  dccpd_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .edge_time (in_time_r),
    .cfg       (cfg),
    .ev        (ev)
  );

  dccpd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ev        (ev),
    .cfg       (cfg),
    .res_ready (out_ch.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid           = res_valid;
  assign out_ch.event_res       = res.event_res;
  assign out_ch.packet_done     = res.packet_done;
  assign out_ch.checksum_ok     = res.checksum_ok;
  assign out_ch.for_this_device = res.for_this_device;
  assign out_ch.address         = res.address;
  assign out_ch.data            = res.data;
  assign out_ch.checksum        = res.checksum;

endmodule

`default_nettype wire

// ===== rtl/dccpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// DCC decoder register file
// Holds the interval windows, preamble length and own address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccpd_cfg_regs import dccpd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CfgIdxBits-1:0]  wr_index,
  input  wire logic [CfgDataBits-1:0] wr_data,
  output      cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_ONE_MIN:      cfg_nxt.one_min      = wr_data[TimeBits-1:0];
        REG_ONE_MAX:      cfg_nxt.one_max      = wr_data[TimeBits-1:0];
        REG_ZERO_MIN:     cfg_nxt.zero_min     = wr_data[TimeBits-1:0];
        REG_ZERO_MAX:     cfg_nxt.zero_max     = wr_data[TimeBits-1:0];
        REG_PREAMBLE_MIN: cfg_nxt.preamble_min = wr_data[7:0];
        REG_OWN_ADDRESS:  cfg_nxt.own_address  = wr_data[7:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_min      <= OneMinRst;
      cfg_r.one_max      <= OneMaxRst;
      cfg_r.zero_min     <= ZeroMinRst;
      cfg_r.zero_max     <= ZeroMaxRst;
      cfg_r.preamble_min <= PreambleMinRst;
      cfg_r.own_address  <= OwnAddressRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/dccpd_classify.sv =====
// ----------------------------------------------------------------------------
// DCC decoder interval classifier
// Forms the wrapped edge interval and sorts it into one of five events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccpd_classify import dccpd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [TimeBits-1:0] edge_time,
  input  wire cfg_t                cfg,
  output      dcc_event_t          ev
);

  logic [TimeBits-1:0] prev_time_r;
  logic [TimeBits-1:0] gap;

  assign gap = edge_time - prev_time_r;

  always_comb begin
    if (gap < cfg.one_min) begin
      ev = EV_GLITCH;
    end else if (gap < cfg.one_max) begin
      ev = EV_ONE;
    end else if (gap < cfg.zero_min) begin
      ev = EV_WRONG_EDGE;
    end else if (gap < cfg.zero_max) begin
      ev = EV_ZERO;
    end else begin
      ev = EV_LONG_GAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
    end else if (step) begin
      prev_time_r <= edge_time;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dccpd_frame.sv =====
// ----------------------------------------------------------------------------
// DCC decoder packet framer
// Tracks the preamble, collects packet bits and registers the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dcc_edge_interval_packet_decoder_core_macros.svh"

module dccpd_frame import dccpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire dcc_event_t ev,
  input  wire cfg_t       cfg,
  input  wire logic       res_ready,
  output      logic       res_valid,
  output      result_t    res
);

  logic [7:0]         pre_r,    pre_nxt;
  logic               in_pkt_r, in_pkt_nxt;
  logic [CntBits-1:0] cnt_r,    cnt_nxt;
  logic [PktBits-1:0] shift_r,  shift_nxt;
  logic               out_vld_r;
  result_t            res_r,    res_nxt;
  logic               have_bit;
  logic               bit_val;

  always_comb begin
    pre_nxt    = pre_r;
    in_pkt_nxt = in_pkt_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    have_bit   = 1'b0;
    bit_val    = 1'b0;
    res_nxt    = '0;
    res_nxt.event_res = ev;

    case (ev)
      EV_ONE: begin
        if (pre_r != 8'hFF) begin
          pre_nxt = pre_r + 8'd1;
        end
        have_bit = 1'b1;
        bit_val  = 1'b1;
      end
      EV_ZERO: begin
        if (pre_r >= cfg.preamble_min) begin
          in_pkt_nxt = 1'b1;
          cnt_nxt    = '0;
          shift_nxt  = '0;
        end
        pre_nxt  = '0;
        have_bit = 1'b1;
      end
      default: begin
        pre_nxt    = '0;
        in_pkt_nxt = 1'b0;
        cnt_nxt    = '0;
      end
    endcase

    if (have_bit && in_pkt_nxt) begin
      shift_nxt = {shift_nxt[PktBits-2:0], bit_val};
      cnt_nxt   = cnt_nxt + CntBits'(1);
      if (cnt_nxt == CntBits'(PktBits)) begin
        res_nxt.packet_done     = 1'b1;
        res_nxt.address         = shift_nxt[30:23];
        res_nxt.data            = shift_nxt[21:14];
        res_nxt.checksum        = shift_nxt[12:5];
        res_nxt.checksum_ok     = ((shift_nxt[30:23] ^ shift_nxt[21:14]) == shift_nxt[12:5]);
        res_nxt.for_this_device = res_nxt.checksum_ok &&
                                  (shift_nxt[30:23] == cfg.own_address);
        in_pkt_nxt = 1'b0;
        cnt_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r     <= '0;
      in_pkt_r  <= 1'b0;
      cnt_r     <= '0;
      shift_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        pre_r    <= pre_nxt;
        in_pkt_r <= in_pkt_nxt;
        cnt_r    <= cnt_nxt;
        shift_r  <= shift_nxt;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (res_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

  `DCCPD_ASSERT(a_cnt_range, cnt_r < CntBits'(PktBits), "bit count reached packet length")
  `DCCPD_ASSERT(a_idle_cnt_zero, !in_pkt_r |-> cnt_r == '0, "bit count nonzero outside a packet")
  `DCCPD_ASSERT(a_done_closes, step && res_nxt.packet_done |=> !in_pkt_r && cnt_r == '0,
                "packet still open after its last bit")

endmodule

`default_nettype wire
